>>> design/pairwise_2d_collider_test_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the pairwise collider test block
// Shared concurrent assertion forms, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef PAIRWISE_2D_COLLIDER_TEST_TOP_ASSERT_SVH
`define PAIRWISE_2D_COLLIDER_TEST_TOP_ASSERT_SVH

// Same-cycle implication.
`define PW2C_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define PW2C_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/pw2c_pkg.sv
// ----------------------------------------------------------------------------
// pw2c_pkg
// Types, constants and defaults shared by the pairwise collider test files.
// ----------------------------------------------------------------------------
package pw2c_pkg;

  // Default configuration.
  localparam int COORD_WIDTH_DEF     = 24;
  localparam int COS_TABLE_DEPTH_DEF = 1024;

  // Fixed field widths.
  localparam int OP_WIDTH  = 3;
  localparam int DIR_WIDTH = 16;
  localparam int AP_WIDTH  = 16;
  localparam int COS_WIDTH = 16;

  // Widths of the direction-length and cosine-square products.
  localparam int DD_WIDTH  = 32;
  localparam int CC_WIDTH  = 29;
  localparam int DDC_WIDTH = DD_WIDTH + CC_WIDTH;

  // The dot-square side is scaled by 2^28 to match the Q14 cosine squared.
  localparam int CMP_SHIFT = 28;

  // Angle constants.
  localparam int unsigned     TWO_PI_Q13 = 51472;
  localparam longint unsigned PI_Q30     = 64'd3373259426;

  // Taylor series for the cosine: divisor (2n-1)*2n of each term.
  localparam int TAYLOR_TERMS = 10;
  localparam longint unsigned TAYLOR_DIV [TAYLOR_TERMS] =
    '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240, 64'd306, 64'd380};

  // Pair kinds.
  typedef enum logic [OP_WIDTH-1:0] {
    OP_CIRC_CIRC = 3'd0,
    OP_CIRC_BOX  = 3'd1,
    OP_BOX_BOX   = 3'd2,
    OP_SECT_CIRC = 3'd3,
    OP_SECT_BOX  = 3'd4,
    OP_SECT_SECT = 3'd5
  } op_t;

endpackage

>>> design/pw2c_pair_if.sv
// ----------------------------------------------------------------------------
// pw2c_pair_if
// Valid/ready channel that carries one collider pair and its opcode.
// ----------------------------------------------------------------------------
interface pw2c_pair_if
  import pw2c_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic [OP_WIDTH-1:0]           opcode;
  logic signed [COORD_WIDTH-1:0] a_p0x;
  logic signed [COORD_WIDTH-1:0] a_p0y;
  logic signed [COORD_WIDTH-1:0] a_p1x;
  logic signed [COORD_WIDTH-1:0] a_p1y;
  logic signed [DIR_WIDTH-1:0]   a_dir_x;
  logic signed [DIR_WIDTH-1:0]   a_dir_y;
  logic [AP_WIDTH-1:0]           a_aperture;
  logic signed [COORD_WIDTH-1:0] b_p0x;
  logic signed [COORD_WIDTH-1:0] b_p0y;
  logic signed [COORD_WIDTH-1:0] b_p1x;
  logic signed [COORD_WIDTH-1:0] b_p1y;

  modport source (
    output valid, opcode, a_p0x, a_p0y, a_p1x, a_p1y, a_dir_x, a_dir_y, a_aperture,
    output b_p0x, b_p0y, b_p1x, b_p1y,
    input  ready
  );
  modport sink (
    input  valid, opcode, a_p0x, a_p0y, a_p1x, a_p1y, a_dir_x, a_dir_y, a_aperture,
    input  b_p0x, b_p0y, b_p1x, b_p1y,
    output ready
  );
endinterface

>>> design/pw2c_hit_if.sv
// ----------------------------------------------------------------------------
// pw2c_hit_if
// Valid/ready channel that carries one hit result.
// ----------------------------------------------------------------------------
interface pw2c_hit_if ();
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink (input valid, hit, output ready);
endinterface

>>> design/pw2c_mul.sv
// ----------------------------------------------------------------------------
// pw2c_mul
// Three-stage unsigned multiplier built from four half-width partial products.
// ----------------------------------------------------------------------------
module pw2c_mul #(
  parameter int AW = 40,
  parameter int BW = 40
) (
  input  logic             clk,
  input  logic [2:0]       en,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic [AW+BW-1:0] p
);
  localparam int AL = (AW + 1) / 2;
  localparam int AH = AW - AL;
  localparam int BL = (BW + 1) / 2;
  localparam int BH = BW - BL;
  localparam int PW = AW + BW;

  logic [AL+BL-1:0] pp00;
  logic [AL+BH-1:0] pp01;
  logic [AH+BL-1:0] pp10;
  logic [AH+BH-1:0] pp11;
  logic [PW-1:0]    sum_lo;
  logic [PW-1:0]    sum_hi;

  // Partial products.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      pp00 <= a[AL-1:0] * b[BL-1:0];
      pp01 <= a[AL-1:0] * b[BW-1:BL];
      pp10 <= a[AW-1:AL] * b[BL-1:0];
      pp11 <= a[AW-1:AL] * b[BW-1:BL];
    end
  end

  // Pairwise sums, then the final sum.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      sum_lo <= PW'(pp00) + (PW'(pp01) << BL);
      sum_hi <= (PW'(pp10) << AL) + (PW'(pp11) << (AL + BL));
    end
    if (en[2]) begin
      p <= sum_lo + sum_hi;
    end
  end
endmodule

>>> design/pw2c_cos.sv
// ----------------------------------------------------------------------------
// pw2c_cos
// Four-stage cosine lookup: aperture to table index by reciprocal
// multiplication with one correction step, then a registered ROM read.
// ----------------------------------------------------------------------------
module pw2c_cos
  import pw2c_pkg::*;
#(
  parameter int COS_TABLE_DEPTH = COS_TABLE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic [3:0]                  en,
  input  logic [AP_WIDTH-1:0]         ap,
  output logic signed [COS_WIDTH-1:0] c
);
  localparam int              D1      = COS_TABLE_DEPTH - 1;
  localparam int              KW      = $clog2(COS_TABLE_DEPTH);
  localparam longint unsigned NUM_MAX = 64'(TWO_PI_Q13) * D1 + TWO_PI_Q13 / 2;
  localparam int              NUMW    = $clog2(NUM_MAX + 1);
  localparam int              RSH     = NUMW + 16;
  localparam longint unsigned RECIP   = (64'd1 << RSH) / TWO_PI_Q13;
  localparam int              RW      = RSH - 15;
  localparam int              PRW     = NUMW + RW;

  typedef logic signed [COS_WIDTH-1:0] rom_t [COS_TABLE_DEPTH];

  // One table entry: cos of half angle k*pi/D1 in Q14, mirrored past pi/2.
  function automatic logic signed [COS_WIDTH-1:0] cos_entry(int unsigned k);
    longint unsigned j;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    longint          cval;
    logic            neg;
    neg = 1'b0;
    j   = 64'(k);
    if (2 * k > D1) begin
      neg = 1'b1;
      j   = 64'(D1 - k);
    end
    x    = j * PI_Q30 / D1;
    x2   = (x * x) >> 30;
    term = 64'd1 << 30;
    sum  = longint'(term);
    for (int n = 0; n < TAYLOR_TERMS; n++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[n];
      if (n % 2 == 0) sum = sum - longint'(term);
      else            sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > (64'sd1 <<< 30)) sum = 64'sd1 <<< 30;
    cval = (sum + 32768) >>> 16;
    return neg ? COS_WIDTH'(-cval) : COS_WIDTH'(cval);
  endfunction

  function automatic rom_t build_rom();
    rom_t r;
    for (int i = 0; i < COS_TABLE_DEPTH; i++) begin
      r[i] = cos_entry(i);
    end
    return r;
  endfunction

  localparam rom_t COS_ROM = build_rom();

  logic [AP_WIDTH-1:0] ap_sat;
  logic [NUMW-1:0]     num2;
  logic [NUMW-1:0]     num3;
  logic [PRW-1:0]      prod;
  logic [KW-1:0]       est3;
  logic [NUMW-1:0]     rem;
  logic [KW-1:0]       k4;

  // Saturate the aperture and form the rounded numerator.
  assign ap_sat = (ap > AP_WIDTH'(TWO_PI_Q13)) ? AP_WIDTH'(TWO_PI_Q13) : ap;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      num2 <= NUMW'(64'(ap_sat) * D1 + TWO_PI_Q13 / 2);
    end
  end

  // Quotient estimate; it is exact or one short.
  assign prod = PRW'(num2) * PRW'(RECIP);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      est3 <= KW'(prod >> RSH);
      num3 <= num2;
    end
  end

  // Correct the estimate with one compare.
  assign rem = num3 - NUMW'(est3 * NUMW'(TWO_PI_Q13));

  always_ff @(posedge clk) begin
    if (en[2]) begin
      k4 <= est3 + KW'(rem >= NUMW'(TWO_PI_Q13));
    end
  end

  // Registered table read.
  always_ff @(posedge clk) begin
    if (en[3]) begin
      c <= COS_ROM[k4];
    end
  end
endmodule

>>> design/pairwise_2d_collider_test_top.sv
// ----------------------------------------------------------------------------
// pairwise_2d_collider_test_top
// Pairwise 2D overlap test for circles, boxes and sectors, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   The pair channel takes one collider pair and an opcode per transfer; the
//   result channel returns one hit bit per pair, in order.
//   Throughput is one pair per cycle while the receiver does not stall.
//   The pipeline has eleven register stages: clamp and select, squares
//   and dot products, sums, cosine index and table read, the cosine square,
//   and two three-stage wide multipliers for the exact angle compare.
//   Every stage has its own valid bit and moves when the next stage is empty
//   or moving, so empty slots fill while the receiver stalls; a stalled
//   result holds in the output register and nothing is lost or repeated.
//   Reset clears all valid bits; the block is ready in the cycle after reset.
//   Unknown opcodes give a hit of zero.
// ----------------------------------------------------------------------------
module pairwise_2d_collider_test_top
  import pw2c_pkg::*;
#(
  parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
  parameter int COS_TABLE_DEPTH = COS_TABLE_DEPTH_DEF
) (
  input logic          clk,
  input logic          rst,
  pw2c_pair_if.sink    pair,
  pw2c_hit_if.source   result
);
  localparam int W     = COORD_WIDTH;
  localparam int DW    = W + 1;
  localparam int TSQW  = 2 * W + 2;
  localparam int PW    = DW + DIR_WIDTH;
  localparam int DOTW  = PW + 1;
  localparam int MDW   = PW;
  localparam int CMPW  = TSQW + DDC_WIDTH;
  localparam int NST   = 11;

  // Stage control.
  logic [NST:1] v;
  logic [NST:1] en;

  always_comb begin
    en[NST] = !v[NST] || result.ready;
    for (int i = NST - 1; i >= 1; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int i = NST; i >= 2; i--) begin
        if (en[i]) v[i] <= v[i-1];
      end
      if (en[1]) v[1] <= pair.valid;
    end
  end

  assign pair.ready   = en[1];
  assign result.valid = v[NST];

  // Stage 1: input register.
  logic [OP_WIDTH-1:0]         s1_op;
  logic signed [W-1:0]         s1_a0x, s1_a0y, s1_a1x, s1_a1y;
  logic signed [W-1:0]         s1_b0x, s1_b0y, s1_b1x, s1_b1y;
  logic signed [DIR_WIDTH-1:0] s1_ux, s1_uy;
  logic [AP_WIDTH-1:0]         s1_ap;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_op  <= pair.opcode;
      s1_a0x <= pair.a_p0x;
      s1_a0y <= pair.a_p0y;
      s1_a1x <= pair.a_p1x;
      s1_a1y <= pair.a_p1y;
      s1_b0x <= pair.b_p0x;
      s1_b0y <= pair.b_p0y;
      s1_b1x <= pair.b_p1x;
      s1_b1y <= pair.b_p1y;
      s1_ux  <= pair.a_dir_x;
      s1_uy  <= pair.a_dir_y;
      s1_ap  <= pair.a_aperture;
    end
  end

  // Cosine of the half aperture, ready at stage 5.
  logic signed [COS_WIDTH-1:0] c5;

  pw2c_cos #(
    .COS_TABLE_DEPTH (COS_TABLE_DEPTH)
  ) u_cos (
    .clk (clk),
    .en  (en[5:2]),
    .ap  (s1_ap),
    .c   (c5)
  );

  // Stage 2: clamp into box B, select the target vector and the reach bound, test box overlap.
  logic signed [W-1:0]  cx, cy, tgt_x, tgt_y;
  logic signed [DW-1:0] tx_c, ty_c, bnd_c;
  logic                 box_c;

  always_comb begin
    cx = (s1_a0x < s1_b0x) ? s1_b0x : ((s1_a0x > s1_b1x) ? s1_b1x : s1_a0x);
    cy = (s1_a0y < s1_b0y) ? s1_b0y : ((s1_a0y > s1_b1y) ? s1_b1y : s1_a0y);
    if (s1_op == OP_CIRC_BOX || s1_op == OP_SECT_BOX) begin
      tgt_x = cx;
      tgt_y = cy;
      bnd_c = {s1_a1x[W-1], s1_a1x};
    end else begin
      tgt_x = s1_b0x;
      tgt_y = s1_b0y;
      bnd_c = {s1_a1x[W-1], s1_a1x} + {s1_b1x[W-1], s1_b1x};
    end
    tx_c  = {tgt_x[W-1], tgt_x} - {s1_a0x[W-1], s1_a0x};
    ty_c  = {tgt_y[W-1], tgt_y} - {s1_a0y[W-1], s1_a0y};
    box_c = !(s1_a0x > s1_b1x || s1_a1x < s1_b0x || s1_a0y > s1_b1y || s1_a1y < s1_b0y);
  end

  logic [OP_WIDTH-1:0]         s2_op;
  logic signed [DW-1:0]        s2_tx, s2_ty, s2_bnd;
  logic                        s2_box;
  logic signed [DIR_WIDTH-1:0] s2_ux, s2_uy;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_op  <= s1_op;
      s2_tx  <= tx_c;
      s2_ty  <= ty_c;
      s2_bnd <= bnd_c;
      s2_box <= box_c;
      s2_ux  <= s1_ux;
      s2_uy  <= s1_uy;
    end
  end

  // Stage 3: squares and dot-product terms.
  logic signed [2*DW-1:0]          sq_tx, sq_ty, sq_bnd;
  logic signed [PW-1:0]            px_c, py_c;
  logic signed [2*DIR_WIDTH-1:0]   sq_ux, sq_uy;

  assign sq_tx  = s2_tx * s2_tx;
  assign sq_ty  = s2_ty * s2_ty;
  assign sq_bnd = s2_bnd * s2_bnd;
  assign px_c   = s2_tx * s2_ux;
  assign py_c   = s2_ty * s2_uy;
  assign sq_ux  = s2_ux * s2_ux;
  assign sq_uy  = s2_uy * s2_uy;

  logic [OP_WIDTH-1:0]  s3_op;
  logic [TSQW-1:0]      s3_tx2, s3_ty2, s3_b2;
  logic signed [PW-1:0] s3_px, s3_py;
  logic [DD_WIDTH-2:0]  s3_ux2, s3_uy2;
  logic                 s3_bneg, s3_deg, s3_box;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_op   <= s2_op;
      s3_tx2  <= TSQW'(sq_tx);
      s3_ty2  <= TSQW'(sq_ty);
      s3_b2   <= TSQW'(sq_bnd);
      s3_px   <= px_c;
      s3_py   <= py_c;
      s3_ux2  <= sq_ux[DD_WIDTH-2:0];
      s3_uy2  <= sq_uy[DD_WIDTH-2:0];
      s3_bneg <= s2_bnd[DW-1];
      s3_deg  <= (s2_tx == '0 && s2_ty == '0) || (s2_ux == '0 && s2_uy == '0);
      s3_box  <= s2_box;
    end
  end

  // Stage 4: sums and the reach check.
  logic [TSQW-1:0] tsq_c;

  assign tsq_c = s3_tx2 + s3_ty2;

  logic [OP_WIDTH-1:0]    s4_op;
  logic [TSQW-1:0]        s4_tsq;
  logic signed [DOTW-1:0] s4_dot;
  logic [DD_WIDTH-1:0]    s4_dd;
  logic                   s4_reach, s4_deg, s4_box;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_op    <= s3_op;
      s4_tsq   <= tsq_c;
      s4_dot   <= DOTW'(s3_px) + DOTW'(s3_py);
      s4_dd    <= DD_WIDTH'(s3_ux2) + DD_WIDTH'(s3_uy2);
      s4_reach <= !s3_bneg && (tsq_c <= s3_b2);
      s4_deg   <= s3_deg;
      s4_box   <= s3_box;
    end
  end

  // Stage 5: dot magnitude; the cosine arrives here.
  logic [OP_WIDTH-1:0] s5_op;
  logic [MDW-1:0]      s5_md;
  logic                s5_dneg;
  logic [TSQW-1:0]     s5_tsq;
  logic [DD_WIDTH-1:0] s5_dd;
  logic                s5_reach, s5_deg, s5_box;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_op    <= s4_op;
      s5_md    <= s4_dot[DOTW-1] ? MDW'(-s4_dot) : MDW'(s4_dot);
      s5_dneg  <= s4_dot[DOTW-1];
      s5_tsq   <= s4_tsq;
      s5_dd    <= s4_dd;
      s5_reach <= s4_reach;
      s5_deg   <= s4_deg;
      s5_box   <= s4_box;
    end
  end

  // Stage 6: cosine square and the decision of every case but the exact compare.
  logic signed [2*COS_WIDTH-1:0] cc_c;
  logic                          pre_c, cmp_c, ge_c;

  assign cc_c = c5 * c5;

  always_comb begin
    pre_c = 1'b0;
    cmp_c = 1'b0;
    ge_c  = 1'b0;
    case (s5_op)
      OP_CIRC_CIRC, OP_CIRC_BOX: begin
        pre_c = s5_reach;
      end
      OP_BOX_BOX: begin
        pre_c = s5_box;
      end
      OP_SECT_CIRC, OP_SECT_BOX, OP_SECT_SECT: begin
        if (!s5_reach) begin
          pre_c = 1'b0;
        end else if (s5_deg) begin
          pre_c = 1'b1;
        end else if (!c5[COS_WIDTH-1]) begin
          if (s5_dneg) begin
            pre_c = 1'b0;
          end else if (c5 == '0) begin
            pre_c = 1'b1;
          end else begin
            cmp_c = 1'b1;
            ge_c  = 1'b1;
          end
        end else if (!s5_dneg) begin
          pre_c = 1'b1;
        end else begin
          cmp_c = 1'b1;
        end
      end
      default: begin
        pre_c = 1'b0;
      end
    endcase
  end

  logic [CC_WIDTH-1:0] s6_cc;
  logic [DD_WIDTH-1:0] s6_dd;
  logic [TSQW-1:0]     s6_tsq;

  // Decision flags ride stages 6 to 10.
  logic [10:6] f_pre, f_cmp, f_ge;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_cc     <= cc_c[CC_WIDTH-1:0];
      s6_dd     <= s5_dd;
      s6_tsq    <= s5_tsq;
      f_pre[6]  <= pre_c;
      f_cmp[6]  <= cmp_c;
      f_ge[6]   <= ge_c;
    end
    for (int i = 7; i <= 10; i++) begin
      if (en[i]) begin
        f_pre[i] <= f_pre[i-1];
        f_cmp[i] <= f_cmp[i-1];
        f_ge[i]  <= f_ge[i-1];
      end
    end
  end

  // Stage 7: direction length squared times cosine squared.
  logic [DDC_WIDTH-1:0] s7_ddc;
  logic [TSQW-1:0]      s7_tsq;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s7_ddc <= DDC_WIDTH'(s6_dd) * DDC_WIDTH'(s6_cc);
      s7_tsq <= s6_tsq;
    end
  end

  // Dot square over stages 6 to 8, aligned to stage 10.
  logic [2*MDW-1:0] lhs_p;
  logic [2*MDW-1:0] s9_lhs, s10_lhs;

  pw2c_mul #(
    .AW (MDW),
    .BW (MDW)
  ) u_mul_lhs (
    .clk (clk),
    .en  (en[8:6]),
    .a   (s5_md),
    .b   (s5_md),
    .p   (lhs_p)
  );

  always_ff @(posedge clk) begin
    if (en[9])  s9_lhs  <= lhs_p;
    if (en[10]) s10_lhs <= s9_lhs;
  end

  // Target length squared times the stage 7 product, over stages 8 to 10.
  logic [CMPW-1:0] rhs_p;

  pw2c_mul #(
    .AW (TSQW),
    .BW (DDC_WIDTH)
  ) u_mul_rhs (
    .clk (clk),
    .en  (en[10:8]),
    .a   (s7_tsq),
    .b   (s7_ddc),
    .p   (rhs_p)
  );

  // Stage 11: exact angle compare and the output register.
  logic [CMPW-1:0] lhs_w;
  logic            hit_c;

  assign lhs_w = CMPW'(s10_lhs) << CMP_SHIFT;
  assign hit_c = f_cmp[10] ? (f_ge[10] ? (lhs_w >= rhs_p) : (lhs_w <= rhs_p)) : f_pre[10];

  always_ff @(posedge clk) begin
    if (en[NST]) begin
      result.hit <= hit_c;
    end
  end
endmodule

>>> design/pw2c_checker.sv
// ----------------------------------------------------------------------------
// pw2c_checker
// Port-level checks of the pairwise collider test block, bound to the top.
// ----------------------------------------------------------------------------
`include "pairwise_2d_collider_test_top_assert.svh"

module pw2c_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic hit
);
  // A stalled result keeps its value.
  `PW2C_ASSERT_NEXT(a_result_hold, out_valid && !out_ready, out_valid && $stable(hit), "hold")

  // When the output register is free or moving, the pipeline takes a pair.
  `PW2C_ASSERT_IMPL(a_ready_free, !out_valid || out_ready, in_ready, "pair not taken")

  // Nothing is shown right after reset.
  `PW2C_ASSERT_IMPL(a_reset_empty, $past(rst), !out_valid, "result valid after reset")

  // The input holds off only while a result waits on a stalled receiver.
  `PW2C_ASSERT_IMPL(a_stall_cause, !in_ready, out_valid && !out_ready, "needless input stall")
endmodule

bind pairwise_2d_collider_test_top pw2c_checker u_pw2c_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (pair.valid),
  .in_ready  (pair.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .hit       (result.hit)
);

>>> test/tb_pairwise_2d_collider_test_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Pairwise collider overlap testbench
// Drives collider pairs of every kind into the block and checks each hit bit
// against a predictor written here. A directed table comes first, then
// random pairs with random gaps, random result stalls and one long hold-off.
// ----------------------------------------------------------------------------
module tb_pairwise_2d_collider_test_top;
  import pw2c_pkg::*;

  localparam int CW = COORD_WIDTH_DEF;
  localparam int N_RANDOM = 800;
  localparam longint CMAX = (64'sd1 <<< (CW - 1)) - 1;
  localparam longint CMIN = -(64'sd1 <<< (CW - 1));
  localparam longint unsigned DEPTH_M1 = COS_TABLE_DEPTH_DEF - 1;

  typedef struct {
    logic [OP_WIDTH-1:0] opcode;
    longint ax0, ay0, ax1, ay1;
    longint ux, uy;
    longint unsigned ap;
    longint bx0, by0, bx1, by1;
  } pair_t;

  logic clk;
  logic rst;
  bit failed;
  bit stim_done;
  int holdoff;

  pw2c_pair_if #(.COORD_WIDTH(CW)) pair_ch ();
  pw2c_hit_if result_ch ();

  pairwise_2d_collider_test_top #(
    .COORD_WIDTH(CW),
    .COS_TABLE_DEPTH(COS_TABLE_DEPTH_DEF)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .pair(pair_ch.sink),
    .result(result_ch.source)
  );

  bit expected_hits[$];
  pair_t row_queue[$];
  // Expected hit of each directed row; -1 means predicted.
  int row_want[$];

  // Magnitude square sum, exact in 128 bits.
  function automatic logic [127:0] sq_sum(longint x, longint y);
    logic [127:0] mx;
    logic [127:0] my;
    mx = (x < 0) ? -x : x;
    my = (y < 0) ? -y : y;
    return mx * mx + my * my;
  endfunction

  function automatic bit within_reach(longint dx, longint dy, longint bound);
    logic [127:0] b;
    if (bound < 0) return 1'b0;
    b = bound;
    return sq_sum(dx, dy) <= b * b;
  endfunction

  // Cosine of half the aperture in Q1.14, from a quantized table angle.
  function automatic int half_cos_q14(longint unsigned ap);
    longint unsigned k, j, x, x2, term;
    longint sum;
    bit neg;
    int c;
    if (ap > TWO_PI_Q13) ap = TWO_PI_Q13;
    k = (ap * DEPTH_M1 + TWO_PI_Q13 / 2) / TWO_PI_Q13;
    if (k > DEPTH_M1) k = DEPTH_M1;
    j = k;
    neg = 1'b0;
    if (2 * k > DEPTH_M1) begin
      neg = 1'b1;
      j = DEPTH_M1 - k;
    end
    x = j * PI_Q30 / DEPTH_M1;
    x2 = (x * x) >> 30;
    term = 64'd1 << 30;
    sum = term;
    for (int n = 1; n <= TAYLOR_TERMS; n++) begin
      term = ((term * x2) >> 30) / longint'((2 * n - 1) * (2 * n));
      if (n % 2 == 1) sum -= term;
      else sum += term;
    end
    if (sum < 0) sum = 0;
    if (sum > (64'sd1 << 30)) sum = 64'sd1 << 30;
    c = int'((longint'(sum) + 32768) >>> 16);
    return neg ? -c : c;
  endfunction

  function automatic bit within_aperture(longint tx, longint ty, longint ux, longint uy,
                                         longint unsigned ap);
    int c;
    longint dot;
    logic [255:0] lhs, rhs, md;
    if (tx == 0 && ty == 0) return 1'b1;
    if (ux == 0 && uy == 0) return 1'b1;
    c = half_cos_q14(ap);
    dot = tx * ux + ty * uy;
    if (c >= 0) begin
      if (dot < 0) return 1'b0;
      if (c == 0) return 1'b1;
    end else if (dot >= 0) begin
      return 1'b1;
    end
    md = (dot < 0) ? -dot : dot;
    lhs = (md * md) << 28;
    rhs = 256'(sq_sum(tx, ty)) * 256'(ux * ux + uy * uy) * 256'(longint'(c) * c);
    return (c >= 0) ? (lhs >= rhs) : (lhs <= rhs);
  endfunction

  function automatic longint clamp_to(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic bit predict_hit(pair_t p);
    longint cx, cy;
    cx = clamp_to(p.ax0, p.bx0, p.bx1);
    cy = clamp_to(p.ay0, p.by0, p.by1);
    case (p.opcode)
      OP_CIRC_CIRC: return within_reach(p.bx0 - p.ax0, p.by0 - p.ay0, p.ax1 + p.bx1);
      OP_CIRC_BOX:  return within_reach(cx - p.ax0, cy - p.ay0, p.ax1);
      OP_BOX_BOX:
        return !(p.ax0 > p.bx1 || p.ax1 < p.bx0 || p.ay0 > p.by1 || p.ay1 < p.by0);
      OP_SECT_CIRC, OP_SECT_SECT:
        return within_reach(p.bx0 - p.ax0, p.by0 - p.ay0, p.ax1 + p.bx1) &&
               within_aperture(p.bx0 - p.ax0, p.by0 - p.ay0, p.ux, p.uy, p.ap);
      OP_SECT_BOX:
        return within_reach(cx - p.ax0, cy - p.ay0, p.ax1) &&
               within_aperture(cx - p.ax0, cy - p.ay0, p.ux, p.uy, p.ap);
      default: return 1'b0;
    endcase
  endfunction

  function automatic pair_t mk(logic [OP_WIDTH-1:0] op, longint ax0, longint ay0,
                               longint ax1, longint ay1, longint ux, longint uy,
                               longint unsigned ap, longint bx0, longint by0,
                               longint bx1, longint by1);
    pair_t p;
    p.opcode = op;
    p.ax0 = ax0; p.ay0 = ay0; p.ax1 = ax1; p.ay1 = ay1;
    p.ux = ux; p.uy = uy; p.ap = ap;
    p.bx0 = bx0; p.by0 = by0; p.bx1 = bx1; p.by1 = by1;
    return p;
  endfunction

  function automatic longint rand_coord(int span);
    if (span == 0) return longint'($signed(24'($urandom)));
    return longint'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic longint rand_dir();
    if ($urandom_range(0, 9) == 0) return 0;
    if ($urandom_range(0, 9) == 0) return longint'($signed(16'($urandom)));
    return longint'($urandom_range(0, 32768)) - 16384;
  endfunction

  // Mostly local scenes so that hits and misses both occur; some full-range noise.
  function automatic pair_t rand_pair();
    pair_t p;
    int span;
    longint r;
    span = ($urandom_range(0, 7) == 0) ? 0 : (1 << $urandom_range(4, 14));
    p.opcode = ($urandom_range(0, 19) == 0) ? OP_WIDTH'($urandom_range(6, 7))
                                             : OP_WIDTH'($urandom_range(0, 5));
    p.ax0 = rand_coord(span);
    p.ay0 = rand_coord(span);
    p.bx0 = rand_coord(span);
    p.by0 = rand_coord(span);
    p.ax1 = rand_coord(span);
    p.ay1 = rand_coord(span);
    p.bx1 = rand_coord(span);
    p.by1 = rand_coord(span);
    if (span != 0 && $urandom_range(0, 3) != 0) begin
      if (p.opcode == OP_BOX_BOX || p.opcode == OP_SECT_BOX || p.opcode == OP_CIRC_BOX) begin
        // Well-formed boxes, and a non-negative radius for A.
        r = p.bx0; if (r > p.bx1) begin p.bx0 = p.bx1; p.bx1 = r; end
        r = p.by0; if (r > p.by1) begin p.by0 = p.by1; p.by1 = r; end
        if (p.opcode == OP_BOX_BOX) begin
          r = p.ax0; if (r > p.ax1) begin p.ax0 = p.ax1; p.ax1 = r; end
          r = p.ay0; if (r > p.ay1) begin p.ay0 = p.ay1; p.ay1 = r; end
        end else if (p.ax1 < 0) begin
          p.ax1 = -p.ax1;
        end
      end else begin
        if (p.ax1 < 0) p.ax1 = -p.ax1;
        if (p.bx1 < 0) p.bx1 = -p.bx1;
      end
    end
    p.ux = rand_dir();
    p.uy = rand_dir();
    p.ap = ($urandom_range(0, 9) == 0) ? longint'($urandom_range(0, 65535))
                                        : longint'($urandom_range(0, TWO_PI_Q13));
    return p;
  endfunction

  // Clock and the single reset at start.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
  end

  // Directed table.
  initial begin
    row_queue.push_back(mk(OP_CIRC_CIRC, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    row_want.push_back(1);
    row_queue.push_back(mk(OP_CIRC_CIRC, CMIN, CMIN, CMAX, 0, 0, 0, 0, CMAX, CMAX, CMAX, 0));
    row_want.push_back(-1);
    row_queue.push_back(mk(OP_CIRC_CIRC, 0, 0, -1, 0, 0, 0, 0, 0, 0, 0, 0));
    row_want.push_back(0);
    row_queue.push_back(mk(OP_CIRC_CIRC, 0, 0, 3, 0, 0, 0, 0, 4, 0, 1, 0));
    row_want.push_back(1);
    row_queue.push_back(mk(OP_CIRC_BOX, 0, 0, 5, 0, 0, 0, 0, 3, -2, 10, 2));
    row_want.push_back(1);
    row_queue.push_back(mk(OP_CIRC_BOX, 0, 0, 5, 0, 0, 0, 0, 10, 3, 3, -3));
    row_want.push_back(-1);
    row_queue.push_back(mk(OP_BOX_BOX, 0, 0, 10, 10, 0, 0, 0, 10, 10, 20, 20));
    row_want.push_back(1);
    row_queue.push_back(mk(OP_BOX_BOX, 0, 0, 10, 10, 0, 0, 0, 11, 0, 20, 20));
    row_want.push_back(0);
    row_queue.push_back(mk(OP_BOX_BOX, CMAX, CMAX, CMIN, CMIN, 0, 0, 0, CMIN, CMIN, CMAX, CMAX));
    row_want.push_back(-1);
    row_queue.push_back(mk(OP_SECT_CIRC, 0, 0, 100, 0, 16384, 0, 12868, 50, 0, 0, 0));
    row_want.push_back(1);
    row_queue.push_back(mk(OP_SECT_CIRC, 0, 0, 100, 0, 16384, 0, 12868, -50, 0, 0, 0));
    row_want.push_back(0);
    row_queue.push_back(mk(OP_SECT_CIRC, 0, 0, 100, 0, 16384, 0, 0, 50, 0, 0, 0));
    row_want.push_back(1);
    row_queue.push_back(mk(OP_SECT_CIRC, 0, 0, 100, 0, 16384, 0, 65535, -50, 0, 0, 0));
    row_want.push_back(1);
    row_queue.push_back(mk(OP_SECT_CIRC, 0, 0, 100, 0, 0, 0, 1000, -50, 7, 0, 0));
    row_want.push_back(1);
    row_queue.push_back(mk(OP_SECT_CIRC, 5, 5, 0, 0, -16384, -16384, 0, 5, 5, 0, 0));
    row_want.push_back(1);
    row_queue.push_back(mk(OP_SECT_CIRC, 0, 0, 100, 0, -32768, 32767, 25736, 30, 40, 0, 0));
    row_want.push_back(-1);
    row_queue.push_back(mk(OP_SECT_BOX, 0, 0, 100, 0, 0, 16384, 6000, -5, 10, 5, 20));
    row_want.push_back(-1);
    row_queue.push_back(mk(OP_SECT_BOX, 0, 0, 100, 0, 0, 16384, 6000, -5, -20, 5, -10));
    row_want.push_back(0);
    row_queue.push_back(mk(OP_SECT_SECT, 0, 0, 10, 0, 16384, 16384, 51472, 5, -5, 5, 0));
    row_want.push_back(-1);
    row_queue.push_back(mk(OP_SECT_SECT, 0, 0, -20, 0, 16384, 0, 51472, 1, 0, 5, 0));
    row_want.push_back(0);
    row_queue.push_back(mk(3'd6, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    row_want.push_back(0);
    row_queue.push_back(mk(3'd7, -1, -1, -1, -1, -1, -1, 65535, -1, -1, -1, -1));
    row_want.push_back(0);
  end

  // Sender: directed rows, then random pairs, some after a random gap.
  initial begin
    pair_t p;
    int gap;
    int n_total;
    bit want_ok;
    pair_ch.valid <= 1'b0;
    pair_ch.opcode <= '0;
    pair_ch.a_p0x <= '0; pair_ch.a_p0y <= '0; pair_ch.a_p1x <= '0; pair_ch.a_p1y <= '0;
    pair_ch.a_dir_x <= '0; pair_ch.a_dir_y <= '0; pair_ch.a_aperture <= '0;
    pair_ch.b_p0x <= '0; pair_ch.b_p0y <= '0; pair_ch.b_p1x <= '0; pair_ch.b_p1y <= '0;
    stim_done = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    n_total = row_queue.size() + N_RANDOM;
    for (int i = 0; i < n_total; i++) begin
      if (i < row_queue.size()) p = row_queue[i];
      else p = rand_pair();
      // Stretches without gaps alternate with gappy ones.
      gap = ((i / 64) % 3 == 0) ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        pair_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pair_ch.valid <= 1'b1;
      pair_ch.opcode <= p.opcode;
      pair_ch.a_p0x <= CW'(p.ax0); pair_ch.a_p0y <= CW'(p.ay0);
      pair_ch.a_p1x <= CW'(p.ax1); pair_ch.a_p1y <= CW'(p.ay1);
      pair_ch.a_dir_x <= 16'(p.ux); pair_ch.a_dir_y <= 16'(p.uy);
      pair_ch.a_aperture <= 16'(p.ap);
      pair_ch.b_p0x <= CW'(p.bx0); pair_ch.b_p0y <= CW'(p.by0);
      pair_ch.b_p1x <= CW'(p.bx1); pair_ch.b_p1y <= CW'(p.by1);
      @(posedge clk);
      while (!pair_ch.ready) @(posedge clk);
      // The transfer happened at this edge; record its prediction.
      expected_hits.push_back(predict_hit(p));
      if (i < row_queue.size() && row_want[i] >= 0) begin
        want_ok = (predict_hit(p) == bit'(row_want[i]));
        if (!want_ok) begin
          $display("%0t: directed row %0d: expected hit %0d, predictor gives %0d",
                   $time, i, row_want[i], predict_hit(p));
          failed = 1'b1;
        end
      end
    end
    pair_ch.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Long receiver hold-off once, so the pipeline fills and stalls its input.
  initial begin
    holdoff = 0;
    while (!(pair_ch.valid && !rst)) @(posedge clk);
    repeat (300) @(posedge clk);
    holdoff = 60;
    while (holdoff > 0) begin
      @(posedge clk);
      holdoff = holdoff - 1;
    end
  end

  // Receiver: random stalls, checks each transfer against the oldest prediction.
  initial begin
    int stall;
    bit exp_hit;
    result_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      while (holdoff > 0) begin
        result_ch.ready <= 1'b0;
        @(posedge clk);
      end
      // Ready stays high until a transfer takes place.
      result_ch.ready <= 1'b1;
      @(posedge clk);
      while (!result_ch.valid) @(posedge clk);
      if (expected_hits.size() == 0) begin
        $display("%0t: unexpected result hit=%0b with nothing pending", $time,
                 result_ch.hit);
        failed = 1'b1;
      end else begin
        exp_hit = expected_hits.pop_front();
        if (result_ch.hit !== exp_hit) begin
          $display("%0t: hit mismatch: expected %0b, actual %0b", $time, exp_hit,
                   result_ch.hit);
          failed = 1'b1;
        end
      end
    end
  end

  // End of run: drain the predictions, then watch for stray results.
  initial begin
    wait (stim_done);
    while (expected_hits.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (!failed) begin
      $display("pairwise_2d_collider_test_top test passed");
    end else begin
      $display("pairwise_2d_collider_test_top test failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("pairwise_2d_collider_test_top test failed");
    $finish;
  end

endmodule

>>> pairwise_2d_collider_test_top.f
+incdir+design
design/pw2c_pkg.sv
design/pw2c_pair_if.sv
design/pw2c_hit_if.sv
design/pw2c_mul.sv
design/pw2c_cos.sv
design/pairwise_2d_collider_test_top.sv
design/pw2c_checker.sv
test/tb_pairwise_2d_collider_test_top.sv
